>>> rtl/core/tsd_pkg.sv
// Package for the traffic strip display: sizes, slot and command codes,
// register indexes and the controller/datapath command and status structs.
// No dependencies; the controller, datapath, top level and checkers import it.
package tsd_pkg;

	// Strip geometry
	localparam int COLUMNS     = 10;
	localparam int DECAY_STEPS = 3;
	localparam int STRIP_ROWS  = 2;
	localparam int COL_W       = $clog2(COLUMNS);
	localparam int PIX_COUNT   = 2 * COLUMNS;
	localparam int PIX_W       = $clog2(PIX_COUNT);

	// Slot codes
	typedef logic [2:0] slot_t;
	localparam slot_t SLOT_EMPTY  = 3'd0;
	localparam slot_t SLOT_HEAD   = 3'd1;
	localparam slot_t SLOT_TAIL   = 3'd2;
	localparam slot_t SLOT_DECAY2 = 3'd3;
	localparam slot_t SLOT_DECAY3 = 3'd4;
	localparam slot_t SLOT_TOOTH  = 3'd5;

	// Input commands
	typedef logic [2:0] cmd_code_t;
	localparam cmd_code_t CMD_TICK      = 3'd0;
	localparam cmd_code_t CMD_RX_FRAMES = 3'd1;
	localparam cmd_code_t CMD_TX_FRAMES = 3'd2;
	localparam cmd_code_t CMD_RX_DROPS  = 3'd3;
	localparam cmd_code_t CMD_TX_FAILS  = 3'd4;
	localparam cmd_code_t CMD_RENDER    = 3'd5;

	// Configuration register indexes
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t CFG_HEAD_PCT   = 3'd0;
	localparam cfg_idx_t CFG_DECAY1_PCT = 3'd1;
	localparam cfg_idx_t CFG_DECAY2_PCT = 3'd2;
	localparam cfg_idx_t CFG_DECAY3_PCT = 3'd3;
	localparam cfg_idx_t CFG_SLOW_IVL   = 3'd4;
	localparam cfg_idx_t CFG_FAST_IVL   = 3'd5;
	localparam cfg_idx_t CFG_IN_ROW     = 3'd6;
	localparam cfg_idx_t CFG_OUT_ROW    = 3'd7;

	// Strip sides
	localparam logic SIDE_IN  = 1'b0;
	localparam logic SIDE_OUT = 1'b1;

	// Row generator seed
	localparam logic [31:0] RAND_SEED = 32'h9E37_79B9;

	// Divide by 100 as multiply by reciprocal; exact for products below 43690
	localparam logic [12:0] RECIP_MUL   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;
	localparam logic [7:0]  CHAN_MAX    = 8'hFF;

	// Controller to datapath
	typedef struct packed {
		logic             load;       // capture the accepted item
		logic             note;       // add event count to a counter
		logic             count;      // advance the tick counter
		logic             step;       // shift one strip and fill its entry
		logic             side;       // strip for step or pixel issue
		logic             issue;      // push a result into the pipeline
		logic             issue_tick; // result is a tick result
		logic [COL_W-1:0] col;        // column of the pixel issued
		logic             last;       // final result of the item
	} tsd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic step_due;  // this tick reaches the interval
		logic issue_ok;  // pipeline stage one can take a result
	} tsd_sts_t;

	// One xorshift32 step
	function automatic logic [31:0] xorshift32(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

endpackage

>>> rtl/core/tsd_if.sv
// Channel interfaces of the traffic strip display: input items, result items
// and the configuration write channel. No dependencies.
interface tsd_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic        slow_band;
	logic [15:0] event_count;
	logic [23:0] bus_color;

	modport source (output valid, command, slow_band, event_count, bus_color, input ready);
	modport sink (input valid, command, slow_band, event_count, bus_color, output ready);
endinterface

interface tsd_result_if;
	logic        valid;
	logic        ready;
	logic        changed;
	logic [3:0]  pixel_column;
	logic [2:0]  pixel_row;
	logic [23:0] pixel_color;
	logic        last;

	modport source (output valid, changed, pixel_column, pixel_row, pixel_color, last,
		input ready);
	modport sink (input valid, changed, pixel_column, pixel_row, pixel_color, last,
		output ready);
endinterface

interface tsd_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/tsd_ctrl.sv
// Controller of the traffic strip display: sequences tick, note and render
// items and issues commands to the datapath. Depends on tsd_pkg.
module tsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [2:0]        in_command,
	output logic              in_ready,
	input  tsd_pkg::tsd_sts_t sts,
	output tsd_pkg::tsd_cmd_t cmd
);
	import tsd_pkg::*;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_NOTE     = 3'd1;
	localparam logic [2:0] ST_COUNT    = 3'd2;
	localparam logic [2:0] ST_STEP_IN  = 3'd3;
	localparam logic [2:0] ST_STEP_OUT = 3'd4;
	localparam logic [2:0] ST_TICK_OUT = 3'd5;
	localparam logic [2:0] ST_RENDER   = 3'd6;

	logic [2:0]       state_q, state_d;
	logic             side_q, side_d;
	logic [COL_W-1:0] col_q, col_d;
	logic             accept;
	logic             col_end;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign col_end  = (col_q == COL_W'(COLUMNS - 1));

	// Next state and commands
	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		col_d   = col_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
				if (accept) begin
					unique case (in_command)
						CMD_TICK: state_d = ST_COUNT;
						CMD_RX_FRAMES, CMD_TX_FRAMES, CMD_RX_DROPS, CMD_TX_FAILS:
							state_d = ST_NOTE;
						CMD_RENDER: begin
							state_d = ST_RENDER;
							side_d  = SIDE_IN;
							col_d   = '0;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_NOTE: begin
				cmd.note = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = sts.step_due ? ST_STEP_IN : ST_TICK_OUT;
			end
			ST_STEP_IN: begin
				cmd.step = 1'b1;
				cmd.side = SIDE_IN;
				state_d  = ST_STEP_OUT;
			end
			ST_STEP_OUT: begin
				cmd.step = 1'b1;
				cmd.side = SIDE_OUT;
				state_d  = ST_TICK_OUT;
			end
			ST_TICK_OUT: begin
				if (sts.issue_ok) begin
					cmd.issue      = 1'b1;
					cmd.issue_tick = 1'b1;
					cmd.last       = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_RENDER: begin
				cmd.side = side_q;
				cmd.col  = col_q;
				cmd.last = (side_q == SIDE_OUT) && col_end;
				if (sts.issue_ok) begin
					cmd.issue = 1'b1;
					if (col_end) begin
						col_d  = '0;
						side_d = SIDE_OUT;
						if (side_q == SIDE_OUT) begin
							state_d = ST_IDLE;
						end
					end else begin
						col_d = col_q + COL_W'(1);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= SIDE_IN;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
			col_q   <= col_d;
		end
	end

endmodule

>>> rtl/core/tsd_dp.sv
// Datapath of the traffic strip display: configuration, strips, counters,
// row generator and the two-stage pixel pipeline. Depends on tsd_pkg, tsd_if.
module tsd_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  tsd_pkg::tsd_cmd_t cmd,
	output tsd_pkg::tsd_sts_t sts,
	input  logic [2:0]        item_command,
	input  logic              item_slow_band,
	input  logic [15:0]       item_event_count,
	input  logic [23:0]       item_bus_color,
	tsd_cfg_if.sink           cfg,
	tsd_result_if.source      result_out
);
	import tsd_pkg::*;

	// Configuration
	logic [6:0] head_pct_q, decay1_pct_q, decay2_pct_q, decay3_pct_q;
	logic [7:0] slow_ivl_q, fast_ivl_q;
	logic [2:0] in_row_q, out_row_q;

	// Captured item
	logic [2:0]  command_q;
	logic        band_q;
	logic [15:0] count_q;
	logic [23:0] color_q;

	// Strip state
	slot_t       slot_q [2][COLUMNS];
	logic        mark_q [2][COLUMNS];
	logic [1:0]  trail_q [2];
	logic [31:0] pending_q [2];
	logic [31:0] failed_q [2];
	logic [7:0]  step_q;
	logic [31:0] rand_q;
	logic        changed_q;

	// Pipeline and output
	logic        valid_s1;
	logic        chg_s1;
	logic [3:0]  col_s1;
	logic [2:0]  row_s1;
	logic [14:0] prod_s1 [3];
	logic        last_s1;
	logic        out_valid_q;
	logic        res_changed_q;
	logic [3:0]  res_col_q;
	logic [2:0]  res_row_q;
	logic [23:0] res_color_q;
	logic        res_last_q;

	logic        out_free, s1_move;
	logic        due_now, s1_open;
	logic [7:0]  cnt_next, interval;
	logic        fail_hit, trail_hit, pend_hit;
	slot_t       fill_code;
	logic        head_fill;
	logic [1:0]  decay_idx;
	logic [31:0] new_rnd;
	logic        new_mark;
	logic        step_chg;
	logic [31:0] note_cur;
	logic [32:0] note_sum;
	logic [31:0] note_res;
	slot_t       rd_code;
	logic        rd_mark;
	logic [6:0]  rd_pct;
	logic [2:0]  rd_row0;

	// Divide a channel product by 100 and clamp to 8 bits
	function automatic logic [7:0] chan_div(input logic [14:0] p);
		logic [27:0] m;
		logic [8:0]  qt;
		m  = 28'(p) * 28'(RECIP_MUL);
		qt = m[RECIP_SHIFT +: 9];
		return (qt > 9'(CHAN_MAX)) ? CHAN_MAX : qt[7:0];
	endfunction

	// Configuration writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_pct_q   <= 7'd100;
			decay1_pct_q <= 7'd60;
			decay2_pct_q <= 7'd30;
			decay3_pct_q <= 7'd10;
			slow_ivl_q   <= 8'd4;
			fast_ivl_q   <= 8'd1;
			in_row_q     <= 3'd0;
			out_row_q    <= 3'd3;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_HEAD_PCT:   head_pct_q   <= cfg.data[6:0];
				CFG_DECAY1_PCT: decay1_pct_q <= cfg.data[6:0];
				CFG_DECAY2_PCT: decay2_pct_q <= cfg.data[6:0];
				CFG_DECAY3_PCT: decay3_pct_q <= cfg.data[6:0];
				CFG_SLOW_IVL:   slow_ivl_q   <= cfg.data;
				CFG_FAST_IVL:   fast_ivl_q   <= cfg.data;
				CFG_IN_ROW:     in_row_q     <= cfg.data[2:0];
				CFG_OUT_ROW:    out_row_q    <= cfg.data[2:0];
			endcase
		end
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= item_command;
			band_q    <= item_slow_band;
			count_q   <= item_event_count;
			color_q   <= item_bus_color;
		end
	end

	// Tick counter
	assign cnt_next = step_q + 8'd1;
	assign interval = band_q ? slow_ivl_q : fast_ivl_q;
	assign due_now  = (cnt_next >= interval);

	// Entry fill for the strip being stepped
	always_comb begin
		fail_hit  = (failed_q[cmd.side] != 32'd0);
		trail_hit = (trail_q[cmd.side] != 2'd0);
		pend_hit  = (pending_q[cmd.side] != 32'd0);
		decay_idx = 2'(DECAY_STEPS) - trail_q[cmd.side];
		new_rnd   = xorshift32(rand_q);
		new_mark  = 1'(new_rnd % 32'(STRIP_ROWS));
		head_fill = 1'b0;
		priority if (fail_hit) begin
			fill_code = SLOT_TOOTH;
		end else if (trail_hit) begin
			fill_code = SLOT_TAIL + {1'b0, decay_idx};
		end else if (pend_hit) begin
			fill_code = SLOT_HEAD;
			head_fill = 1'b1;
		end else begin
			fill_code = SLOT_EMPTY;
		end
	end

	// Any slot differs after the shift
	always_comb begin
		step_chg = 1'b0;
		if (cmd.side == SIDE_IN) begin
			for (int x = 0; x < COLUMNS - 1; x++) begin
				step_chg = step_chg | (slot_q[0][x] != slot_q[0][x + 1]);
			end
			step_chg = step_chg | (slot_q[0][COLUMNS - 1] != fill_code);
		end else begin
			for (int x = 1; x < COLUMNS; x++) begin
				step_chg = step_chg | (slot_q[1][x] != slot_q[1][x - 1]);
			end
			step_chg = step_chg | (slot_q[1][0] != fill_code);
		end
	end

	// Note add with 32-bit saturation
	always_comb begin
		priority case (command_q)
			CMD_RX_FRAMES: note_cur = pending_q[0];
			CMD_TX_FRAMES: note_cur = pending_q[1];
			CMD_RX_DROPS:  note_cur = failed_q[0];
			default:       note_cur = failed_q[1];
		endcase
		note_sum = {1'b0, note_cur} + 33'(count_q);
		note_res = note_sum[32] ? '1 : note_sum[31:0];
	end

	// Strips
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				for (int x = 0; x < COLUMNS; x++) begin
					slot_q[s][x] <= SLOT_EMPTY;
					mark_q[s][x] <= 1'b0;
				end
			end
		end else if (cmd.step) begin
			if (cmd.side == SIDE_IN) begin
				for (int x = 0; x < COLUMNS - 1; x++) begin
					slot_q[0][x] <= slot_q[0][x + 1];
					mark_q[0][x] <= mark_q[0][x + 1];
				end
				slot_q[0][COLUMNS - 1] <= fill_code;
				if (head_fill) begin
					mark_q[0][COLUMNS - 1] <= new_mark;
				end
			end else begin
				for (int x = 1; x < COLUMNS; x++) begin
					slot_q[1][x] <= slot_q[1][x - 1];
					mark_q[1][x] <= mark_q[1][x - 1];
				end
				slot_q[1][0] <= fill_code;
				if (head_fill) begin
					mark_q[1][0] <= new_mark;
				end
			end
		end
	end

	// Counters, trail, row generator, tick flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				trail_q[s]   <= 2'd0;
				pending_q[s] <= 32'd0;
				failed_q[s]  <= 32'd0;
			end
			step_q    <= 8'd0;
			rand_q    <= RAND_SEED;
			changed_q <= 1'b0;
		end else begin
			if (cmd.note) begin
				priority case (command_q)
					CMD_RX_FRAMES: pending_q[0] <= note_res;
					CMD_TX_FRAMES: pending_q[1] <= note_res;
					CMD_RX_DROPS:  failed_q[0]  <= note_res;
					default:       failed_q[1]  <= note_res;
				endcase
			end
			if (cmd.count) begin
				step_q    <= due_now ? 8'd0 : cnt_next;
				changed_q <= 1'b0;
			end
			if (cmd.step) begin
				changed_q <= changed_q | step_chg;
				priority if (fail_hit) begin
					failed_q[cmd.side] <= failed_q[cmd.side] - 32'd1;
					if (pend_hit) begin
						pending_q[cmd.side] <= pending_q[cmd.side] - 32'd1;
					end
					trail_q[cmd.side] <= 2'd0;
				end else if (trail_hit) begin
					trail_q[cmd.side] <= trail_q[cmd.side] - 2'd1;
				end else if (pend_hit) begin
					pending_q[cmd.side] <= pending_q[cmd.side] - 32'd1;
					trail_q[cmd.side]   <= 2'(DECAY_STEPS);
					rand_q              <= new_rnd;
				end
			end
		end
	end

	// Pipeline flow
	assign out_free = !out_valid_q || result_out.ready;
	assign s1_move  = valid_s1 && out_free;
	assign s1_open  = !valid_s1 || s1_move;

	// Status to the controller
	assign sts = '{step_due: due_now, issue_ok: s1_open};

	// Column read for the pixel being issued
	always_comb begin
		rd_code = slot_q[cmd.side][cmd.col];
		rd_mark = mark_q[cmd.side][cmd.col];
		rd_row0 = (cmd.side == SIDE_OUT) ? out_row_q : in_row_q;
		unique case (rd_code)
			SLOT_HEAD:   rd_pct = head_pct_q;
			SLOT_TAIL:   rd_pct = decay1_pct_q;
			SLOT_DECAY2: rd_pct = decay2_pct_q;
			SLOT_DECAY3: rd_pct = decay3_pct_q;
			default:     rd_pct = 7'd0;
		endcase
	end

	// Stage one: channel times percent for a pixel, zeros for a tick
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			last_s1 <= cmd.last;
			if (cmd.issue_tick) begin
				chg_s1 <= changed_q;
				col_s1 <= 4'd0;
				row_s1 <= 3'd0;
				for (int c = 0; c < 3; c++) begin
					prod_s1[c] <= 15'd0;
				end
			end else begin
				chg_s1 <= 1'b0;
				col_s1 <= 4'(cmd.col);
				row_s1 <= rd_row0 + 3'(rd_mark);
				for (int c = 0; c < 3; c++) begin
					prod_s1[c] <= 15'(color_q[8 * c +: 8]) * 15'(rd_pct);
				end
			end
		end
	end

	// Stage two: divide by 100 into the output register
	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_changed_q <= chg_s1;
			res_col_q     <= col_s1;
			res_row_q     <= row_s1;
			res_color_q   <= {chan_div(prod_s1[2]), chan_div(prod_s1[1]), chan_div(prod_s1[0])};
			res_last_q    <= last_s1;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.changed      = res_changed_q;
	assign result_out.pixel_column = res_col_q;
	assign result_out.pixel_row    = res_row_q;
	assign result_out.pixel_color  = res_color_q;
	assign result_out.last         = res_last_q;

endmodule

>>> rtl/core/traffic_strip_display.sv
// Tick: one result after the count state, two strip steps when the interval
// is reached, and two pipeline stages; note: no result; render: 20 pixels,
// one per cycle when the sink keeps ready high, through the same stages.
// One item at a time; the controller's sequence sets the rate.
// Reset clears strips, counters, row generator and config to their defaults.
// Top level of the traffic strip display; depends on tsd_pkg, tsd_if,
// tsd_ctrl and tsd_dp.
module traffic_strip_display (
	input  logic         clk,
	input  logic         arst_n,
	tsd_item_if.sink     item_in,
	tsd_result_if.source result_out,
	tsd_cfg_if.sink      cfg
);
	import tsd_pkg::*;

	tsd_cmd_t cmd;
	tsd_sts_t sts;

	tsd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item_in.valid),
		.in_command (item_in.command),
		.in_ready   (item_in.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	tsd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.item_command     (item_in.command),
		.item_slow_band   (item_in.slow_band),
		.item_event_count (item_in.event_count),
		.item_bus_color   (item_in.bus_color),
		.cfg              (cfg),
		.result_out       (result_out)
	);

endmodule

>>> rtl/core/tsd_chk.sv
// Port checker for the traffic strip display and its bind to the top level.
// Depends on tsd_pkg.
module tsd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        out_changed,
	input logic [3:0]  out_column,
	input logic [2:0]  out_row,
	input logic [23:0] out_color,
	input logic        out_last
);
	import tsd_pkg::*;

	logic             out_acc;
	logic             open_q;
	logic [3:0]       prev_col_q;
	logic [PIX_W-1:0] burst_q;
	logic [3:0]       exp_col;

	assign out_acc = out_valid && out_ready;
	assign exp_col = (prev_col_q == 4'(COLUMNS - 1)) ? 4'd0 : prev_col_q + 4'd1;

	// Track the render burst in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q     <= 1'b0;
			prev_col_q <= 4'd0;
			burst_q    <= '0;
		end else if (out_acc) begin
			if (out_last) begin
				open_q  <= 1'b0;
				burst_q <= '0;
			end else begin
				open_q     <= 1'b1;
				prev_col_q <= out_column;
				burst_q    <= burst_q + PIX_W'(1);
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({out_changed, out_column, out_row, out_color, out_last}))
		else $error("result changed while stalled");

	a_col_seq: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && open_q |-> out_column == exp_col)
		else $error("render column out of sequence");

	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_last && open_q |->
			burst_q == PIX_W'(PIX_COUNT - 1) && out_column == 4'(COLUMNS - 1))
		else $error("render burst has wrong length");

	a_tick_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_changed |-> out_last && out_color == 24'd0 && out_column == 4'd0
			&& !open_q)
		else $error("changed flag on a pixel result");

endmodule

bind traffic_strip_display tsd_chk u_tsd_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result_out.valid),
	.out_ready   (result_out.ready),
	.out_changed (result_out.changed),
	.out_column  (result_out.pixel_column),
	.out_row     (result_out.pixel_row),
	.out_color   (result_out.pixel_color),
	.out_last    (result_out.last)
);

>>> dv/traffic_strip_display_check.sv
// Checker for the traffic strip display: watches the item, result and config
// channels, keeps its own copy of both strips and compares every result item.
// Depends on tsd_pkg and the channel interfaces in tsd_if.
module traffic_strip_display_check (
	input  logic  clk,
	input  logic  arst_n,
	tsd_item_if   item,
	tsd_result_if result,
	tsd_cfg_if    cfg,
	output int    fail_count,
	output int    owed_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	localparam logic [31:0] ROW_SEED = 32'h9E37_79B9;

	typedef struct packed {
		logic        changed;
		logic [3:0]  column;
		logic [2:0]  row;
		logic [23:0] color;
		logic        last;
	} strip_out_t;

	// Pixels and tick flags still to come, oldest first
	strip_out_t pixels_owed [$];

	// Shadow of the strips and counters
	slot_t       lane_slot [2][COLUMNS];
	logic        lane_row  [2][COLUMNS];
	logic [1:0]  trail_left [2];
	logic [31:0] frames_pend [2];
	logic [31:0] frames_bad  [2];
	logic [7:0]  tick_count;
	logic [31:0] row_word;

	// Shadow of the registers
	logic [6:0] pct_head, pct_d1, pct_d2, pct_d3;
	logic [7:0] ivl_slow, ivl_fast;
	logic [2:0] row_in, row_out;

	int mism = 0;

	function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [15:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {17'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [6:0] pct);
		logic [15:0] v;
		v = (16'(c) * 16'(pct)) / 16'd100;
		return (v > 16'h00FF) ? 8'hFF : v[7:0];
	endfunction

	function automatic logic [6:0] percent_of(input slot_t code);
		case (code)
			SLOT_HEAD:   return pct_head;
			SLOT_TAIL:   return pct_d1;
			SLOT_DECAY2: return pct_d2;
			SLOT_DECAY3: return pct_d3;
			default:     return 7'd0;
		endcase
	endfunction

	// Shift one strip by a column and fill the column that opens; 1 if any slot moved
	function automatic logic shift_lane(input logic side);
		slot_t prior [COLUMNS];
		int    entry;
		int    idx;
		logic  moved;
		for (int x = 0; x < COLUMNS; x++) prior[x] = lane_slot[side][x];
		if (side == SIDE_IN) begin
			for (int x = 0; x < COLUMNS - 1; x++) begin
				lane_slot[side][x] = lane_slot[side][x + 1];
				lane_row[side][x]  = lane_row[side][x + 1];
			end
			entry = COLUMNS - 1;
		end else begin
			for (int x = COLUMNS - 1; x > 0; x--) begin
				lane_slot[side][x] = lane_slot[side][x - 1];
				lane_row[side][x]  = lane_row[side][x - 1];
			end
			entry = 0;
		end
		// tooth beats trail beats new head; the entry keeps its row unless a head lands
		if (frames_bad[side] != 0) begin
			frames_bad[side] = frames_bad[side] - 1;
			if (frames_pend[side] != 0) frames_pend[side] = frames_pend[side] - 1;
			trail_left[side] = 2'd0;
			lane_slot[side][entry] = SLOT_TOOTH;
		end else if (trail_left[side] != 0) begin
			idx = (DECAY_STEPS - int'(trail_left[side])) & 3;
			trail_left[side] = trail_left[side] - 2'd1;
			lane_slot[side][entry] = slot_t'(int'(SLOT_TAIL) + idx);
		end else if (frames_pend[side] != 0) begin
			frames_pend[side] = frames_pend[side] - 1;
			trail_left[side] = 2'(DECAY_STEPS);
			row_word = row_word ^ (row_word << 13);
			row_word = row_word ^ (row_word >> 17);
			row_word = row_word ^ (row_word << 5);
			lane_row[side][entry] = 1'(row_word % STRIP_ROWS);
			lane_slot[side][entry] = SLOT_HEAD;
		end else begin
			lane_slot[side][entry] = SLOT_EMPTY;
		end
		moved = 1'b0;
		for (int x = 0; x < COLUMNS; x++)
			if (lane_slot[side][x] != prior[x]) moved = 1'b1;
		return moved;
	endfunction

	// Apply one accepted item and queue the results it causes
	function automatic void play_command(input logic [2:0] cmd, input logic band,
		input logic [15:0] amount, input logic [23:0] rgb);
		strip_out_t o;
		logic [7:0] ivl;
		logic       moved_in, moved_out;
		logic [2:0] base;
		logic [6:0] pct;
		int         k;
		case (cmd)
			CMD_TICK: begin
				ivl = band ? ivl_slow : ivl_fast;
				moved_in = 1'b0;
				moved_out = 1'b0;
				tick_count = tick_count + 8'd1;
				if (tick_count >= ivl) begin
					tick_count = 8'd0;
					moved_in = shift_lane(SIDE_IN);
					moved_out = shift_lane(SIDE_OUT);
				end
				o = '0;
				o.changed = moved_in | moved_out;
				o.last = 1'b1;
				pixels_owed.push_back(o);
			end
			CMD_RX_FRAMES: frames_pend[SIDE_IN]  = add_clamped(frames_pend[SIDE_IN], amount);
			CMD_TX_FRAMES: frames_pend[SIDE_OUT] = add_clamped(frames_pend[SIDE_OUT], amount);
			CMD_RX_DROPS:  frames_bad[SIDE_IN]   = add_clamped(frames_bad[SIDE_IN], amount);
			CMD_TX_FAILS:  frames_bad[SIDE_OUT]  = add_clamped(frames_bad[SIDE_OUT], amount);
			CMD_RENDER: begin
				k = 0;
				for (int s = 0; s < 2; s++) begin
					base = (s == SIDE_IN) ? row_in : row_out;
					for (int x = 0; x < COLUMNS; x++) begin
						o = '0;
						o.column = 4'(x);
						o.row = base + {2'b0, lane_row[s][x]};
						if (lane_slot[s][x] != SLOT_EMPTY && lane_slot[s][x] != SLOT_TOOTH) begin
							pct = percent_of(lane_slot[s][x]);
							o.color = {dim_channel(rgb[23:16], pct), dim_channel(rgb[15:8], pct),
								dim_channel(rgb[7:0], pct)};
						end
						o.last = (k == PIX_COUNT - 1);
						pixels_owed.push_back(o);
						k++;
					end
				end
			end
			default: ;  // spare codes do nothing
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mism++;
		end
	endfunction

	// Sample all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		strip_out_t want;
		if (!arst_n) begin
			for (int s = 0; s < 2; s++) begin
				for (int x = 0; x < COLUMNS; x++) begin
					lane_slot[s][x] = SLOT_EMPTY;
					lane_row[s][x] = 1'b0;
				end
				trail_left[s] = 2'd0;
				frames_pend[s] = 32'd0;
				frames_bad[s] = 32'd0;
			end
			tick_count = 8'd0;
			row_word = ROW_SEED;
			pct_head = 7'd100;
			pct_d1 = 7'd60;
			pct_d2 = 7'd30;
			pct_d3 = 7'd10;
			ivl_slow = 8'd4;
			ivl_fast = 8'd1;
			row_in = 3'd0;
			row_out = 3'd3;
			pixels_owed.delete();
			fail_count <= mism;
			owed_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_HEAD_PCT:   pct_head = cfg.data[6:0];
					CFG_DECAY1_PCT: pct_d1 = cfg.data[6:0];
					CFG_DECAY2_PCT: pct_d2 = cfg.data[6:0];
					CFG_DECAY3_PCT: pct_d3 = cfg.data[6:0];
					CFG_SLOW_IVL:   ivl_slow = cfg.data;
					CFG_FAST_IVL:   ivl_fast = cfg.data;
					CFG_IN_ROW:     row_in = cfg.data[2:0];
					CFG_OUT_ROW:    row_out = cfg.data[2:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (pixels_owed.size() == 0) begin
					$error("result item with nothing owed: changed %0d col %0d row %0d color 0x%0h",
						result.changed, result.pixel_column, result.pixel_row, result.pixel_color);
					mism++;
				end else begin
					want = pixels_owed.pop_front();
					check_field("changed", 32'(want.changed), 32'(result.changed));
					check_field("pixel_column", 32'(want.column), 32'(result.pixel_column));
					check_field("pixel_row", 32'(want.row), 32'(result.pixel_row));
					check_field("pixel_color", 32'(want.color), 32'(result.pixel_color));
					check_field("last", 32'(want.last), 32'(result.last));
				end
			end
			if (item.valid && item.ready)
				play_command(item.command, item.slow_band, item.event_count, item.bus_color);
			fail_count <= mism;
			owed_count <= pixels_owed.size();
		end
	end

endmodule

>>> dv/traffic_strip_display_test.sv
// Top of the traffic strip display test: clock, reset, item and config
// stimulus, result back-pressure, watchdog and verdict. Depends on tsd_pkg,
// tsd_if, the block and traffic_strip_display_check.
module traffic_strip_display_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	localparam cmd_code_t CMD_SPARE_A = 3'd6;
	localparam cmd_code_t CMD_SPARE_B = 3'd7;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 60;
	localparam int SETTLE_CYCLES = 12;
	localparam int TAIL_CYCLES   = 30;
	localparam int QUIET_LIMIT   = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;
	int   stall_pct = 0;
	int   send_idle = 0;
	int   fail_count;
	int   results_owed;
	int   quiet = 0;

	tsd_item_if   item_if ();
	tsd_result_if result_if ();
	tsd_cfg_if    cfg_if ();

	assign result_if.ready = sink_ready;

	traffic_strip_display u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_if),
		.result_out (result_if),
		.cfg        (cfg_if)
	);

	traffic_strip_display_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_if),
		.result     (result_if),
		.cfg        (cfg_if),
		.fail_count (fail_count),
		.owed_count (results_owed)
	);

	always #2 clk = ~clk;

	// Result back-pressure
	always @(posedge clk) begin
		sink_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Watchdog: too long with no handshake on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("traffic_strip_display: mismatch");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	// Present one item, with a random gap first; valid stays high after accept
	task automatic send_item(input cmd_code_t cmd, input logic band, input logic [15:0] amount,
		input logic [23:0] rgb);
		while ($urandom_range(0, 99) < send_idle) begin
			item_if.valid <= 1'b0;
			@(posedge clk);
		end
		item_if.valid <= 1'b1;
		item_if.command <= cmd;
		item_if.slow_band <= band;
		item_if.event_count <= amount;
		item_if.bus_color <= rgb;
		@(posedge clk);
		while (!item_if.ready) @(posedge clk);
	endtask

	// Hold off until every owed result is in, then let the block go quiet
	task automatic settle();
		item_if.valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [7:0] reg_val [8];
		int         pick;
		cmd_code_t  cmd;
		logic [15:0] amount;

		item_if.valid <= 1'b0;
		item_if.command <= CMD_TICK;
		item_if.slow_band <= 1'b0;
		item_if.event_count <= 16'd0;
		item_if.bus_color <= 24'd0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_HEAD_PCT;
		cfg_if.data <= 8'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty strips, heads and trails, teeth, spare codes, band change
		send_item(CMD_RENDER, 1'b0, 16'h0000, 24'hFFFFFF);
		send_item(CMD_TICK, 1'b0, 16'h0000, 24'h000000);
		send_item(CMD_RX_FRAMES, 1'b0, 16'd2, 24'h000000);
		send_item(CMD_TX_FRAMES, 1'b0, 16'd1, 24'h000000);
		send_item(CMD_TICK, 1'b0, 16'h0000, 24'h000000);
		send_item(CMD_RENDER, 1'b0, 16'h0000, 24'hFFFFFF);
		send_item(CMD_TICK, 1'b0, 16'h0000, 24'h000000);
		send_item(CMD_TICK, 1'b0, 16'h0000, 24'h000000);
		send_item(CMD_RENDER, 1'b0, 16'h0000, 24'h123456);
		send_item(CMD_RX_DROPS, 1'b0, 16'd1, 24'h000000);
		send_item(CMD_TX_FAILS, 1'b0, 16'd2, 24'h000000);
		send_item(CMD_TICK, 1'b0, 16'h0000, 24'h000000);
		send_item(CMD_TICK, 1'b0, 16'h0000, 24'h000000);
		send_item(CMD_RENDER, 1'b0, 16'h0000, 24'hFFFFFF);
		send_item(CMD_SPARE_A, 1'b1, 16'd5, 24'hFFFFFF);
		send_item(CMD_SPARE_B, 1'b0, 16'hFFFF, 24'h000000);
		send_item(CMD_RX_FRAMES, 1'b0, 16'd1, 24'h000000);
		send_item(CMD_TICK, 1'b1, 16'h0000, 24'h000000);
		send_item(CMD_TICK, 1'b1, 16'h0000, 24'h000000);
		send_item(CMD_TICK, 1'b1, 16'h0000, 24'h000000);
		send_item(CMD_TICK, 1'b0, 16'h0000, 24'h000000);
		send_item(CMD_TX_FRAMES, 1'b0, 16'd0, 24'h000000);
		send_item(CMD_RENDER, 1'b0, 16'h0000, 24'h000000);

		// Random phases, each under a register setting and an idle mode chosen per phase
		for (int p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				settle();
				case (p)
					1: begin
						reg_val[CFG_HEAD_PCT] = 8'd0;
						reg_val[CFG_DECAY1_PCT] = 8'd100;
						reg_val[CFG_DECAY2_PCT] = 8'hFF;
						reg_val[CFG_DECAY3_PCT] = 8'd0;
						reg_val[CFG_SLOW_IVL] = 8'd255;
						reg_val[CFG_FAST_IVL] = 8'd1;
						reg_val[CFG_IN_ROW] = 8'hFF;
						reg_val[CFG_OUT_ROW] = 8'd7;
					end
					2: begin
						// percent above 100, interval zero, rows that wrap
						reg_val[CFG_HEAD_PCT] = 8'd127;
						reg_val[CFG_DECAY1_PCT] = 8'd101;
						reg_val[CFG_DECAY2_PCT] = 8'd1;
						reg_val[CFG_DECAY3_PCT] = 8'd100;
						reg_val[CFG_SLOW_IVL] = 8'd0;
						reg_val[CFG_FAST_IVL] = 8'd0;
						reg_val[CFG_IN_ROW] = 8'd7;
						reg_val[CFG_OUT_ROW] = 8'd6;
					end
					3: begin
						for (int r = 0; r < 8; r++) reg_val[r] = 8'($urandom_range(0, 255));
					end
					4: begin
						reg_val[CFG_HEAD_PCT] = 8'($urandom_range(0, 100));
						reg_val[CFG_DECAY1_PCT] = 8'($urandom_range(0, 100));
						reg_val[CFG_DECAY2_PCT] = 8'($urandom_range(0, 100));
						reg_val[CFG_DECAY3_PCT] = 8'($urandom_range(0, 100));
						reg_val[CFG_SLOW_IVL] = 8'($urandom_range(1, 8));
						reg_val[CFG_FAST_IVL] = 8'($urandom_range(1, 3));
						reg_val[CFG_IN_ROW] = 8'($urandom_range(0, 7));
						reg_val[CFG_OUT_ROW] = 8'($urandom_range(0, 7));
					end
					default: begin
						reg_val[CFG_HEAD_PCT] = 8'd100;
						reg_val[CFG_DECAY1_PCT] = 8'd60;
						reg_val[CFG_DECAY2_PCT] = 8'd30;
						reg_val[CFG_DECAY3_PCT] = 8'd10;
						reg_val[CFG_SLOW_IVL] = 8'd4;
						reg_val[CFG_FAST_IVL] = 8'd1;
						reg_val[CFG_IN_ROW] = 8'd0;
						reg_val[CFG_OUT_ROW] = 8'd3;
					end
				endcase
				for (int r = 0; r < 8; r++) begin
					cfg_if.valid <= 1'b1;
					cfg_if.index <= cfg_idx_t'(r);
					cfg_if.data <= reg_val[r];
					@(posedge clk);
					while (!cfg_if.ready) @(posedge clk);
				end
				cfg_if.valid <= 1'b0;
			end

			case (p % 4)
				0: begin send_idle = 0;  stall_pct <= 0;  end
				1: begin send_idle = 58; stall_pct <= 0;  end
				2: begin send_idle = 0;  stall_pct <= 58; end
				default: begin send_idle = 36; stall_pct <= 36; end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 49) == 0) settle();
				pick = $urandom_range(0, 99);
				amount = 16'($urandom_range(0, 65535));
				if (pick < 40) cmd = CMD_TICK;
				else if (pick < 52) cmd = CMD_RX_FRAMES;
				else if (pick < 64) cmd = CMD_TX_FRAMES;
				else if (pick < 69) cmd = CMD_RX_DROPS;
				else if (pick < 74) cmd = CMD_TX_FAILS;
				else if (pick < 96) cmd = CMD_RENDER;
				else cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;
				// keep counters small so the strips keep changing
				if (cmd == CMD_RX_FRAMES || cmd == CMD_TX_FRAMES)
					amount = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(4, 40))
						: 16'($urandom_range(0, 3));
				else if (cmd == CMD_RX_DROPS || cmd == CMD_TX_FAILS)
					amount = 16'($urandom_range(0, 3));
				send_item(cmd, 1'($urandom_range(0, 1)), amount, 24'($urandom_range(0, 24'hFFFFFF)));
			end
		end

		// Drain and let the block go idle
		item_if.valid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("traffic_strip_display: match");
		else
			$display("traffic_strip_display: mismatch");
		$finish;
	end

endmodule
